// ===== src/tlq_pkg.sv =====
package tlq_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam logic [4:0] MAX_HOUR   = 5'd23;
    localparam logic [5:0] MAX_MINUTE = 6'd59;
    localparam logic [1:0] LOW_LEVEL  = 2'd3;
    localparam logic [1:0] NO_LEVEL   = 2'd0;

    localparam logic [1:0] ACT_REGISTER = 2'd0;
    localparam logic [1:0] ACT_SET_PRIO = 2'd1;
    localparam logic [1:0] ACT_SERVE    = 2'd2;
    localparam logic [1:0] ACT_LOOKUP   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_BAD      = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [15:0] id;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [1:0]  level;
        logic [31:0] order;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic free_hit;
        logic best_hit;
    } scan_status_t;

endpackage

// ===== src/tlq_slot_mem.sv =====
module tlq_slot_mem
    import tlq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_CAPACITY,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/tlq_scan.sv =====
module tlq_scan
    import tlq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_CAPACITY,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic          rd_vld,
    input  logic [AW-1:0] rd_idx,
    input  entry_t        rd_entry,
    input  logic [15:0]   key_id,
    output scan_status_t  status,
    output logic [AW-1:0] match_idx,
    output entry_t        match_entry,
    output logic [AW-1:0] free_idx,
    output logic [AW-1:0] best_idx,
    output entry_t        best_entry
);

    scan_status_t status_reg;
    logic         is_match;
    logic         is_free;
    logic         is_better;
    logic [44:0]  rd_key;
    logic [44:0]  best_key;

    assign rd_key   = {rd_entry.level, rd_entry.hour, rd_entry.minute, rd_entry.order};
    assign best_key = {best_entry.level, best_entry.hour, best_entry.minute, best_entry.order};

    assign is_match  = rd_entry.valid && (rd_entry.id == key_id) && !status_reg.hit;
    assign is_free   = !rd_entry.valid && !status_reg.free_hit;
    assign is_better = rd_entry.valid && (!status_reg.best_hit || (rd_key < best_key));

    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            status_reg <= '0;
        end else if (rd_vld) begin
            if (is_match) begin
                status_reg.hit <= 1'b1;
            end
            if (is_free) begin
                status_reg.free_hit <= 1'b1;
            end
            if (is_better) begin
                status_reg.best_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld) begin
            if (is_match) begin
                match_idx   <= rd_idx;
                match_entry <= rd_entry;
            end
            if (is_free) begin
                free_idx <= rd_idx;
            end
            if (is_better) begin
                best_idx   <= rd_idx;
                best_entry <= rd_entry;
            end
        end
    end

    assign status = status_reg;

endmodule

// ===== src/three_level_ticket_queue.sv =====
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   action, ticket_id, arrival_hour, arrival_minute, new_level
// m_       out        m_valid / m_ready   status, found_id, found_hour, found_minute,
//                                         found_level, pending_count
//
// In a transaction the slot memory is swept one entry per cycle through its single read port,
// then the S_FINISH state writes back and loads the result.
// After reset a clearing pass marks every slot free; s_ready stays low during it.
// A new transaction is taken while the previous result waits on m_; the write-back holds
// until the output register is free.
module three_level_ticket_queue
    import tlq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    localparam int AW = $clog2(CAPACITY),
    localparam int HW = $clog2(CAPACITY + 1)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [15:0] s_ticket_id,
    input  logic [4:0]  s_arrival_hour,
    input  logic [5:0]  s_arrival_minute,
    input  logic [1:0]  s_new_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_found_id,
    output logic [4:0]  m_found_hour,
    output logic [5:0]  m_found_minute,
    output logic [1:0]  m_found_level,
    output logic [6:0]  m_pending_count
);

    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] addr_reg;
    logic          issue_done_reg;
    logic          data_vld_reg;
    logic [AW-1:0] data_idx_reg;
    logic [HW-1:0] held_count_reg, held_count_next;
    logic [31:0]   insert_counter_reg, insert_counter_next;

    logic [1:0]  action_reg;
    logic [15:0] id_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [1:0]  level_reg;

    logic        m_valid_reg;
    logic [2:0]  status_reg, status_next;
    logic [15:0] found_id_reg;
    logic [4:0]  found_hour_reg;
    logic [5:0]  found_minute_reg;
    logic [1:0]  found_level_reg;
    logic [6:0]  pending_reg;

    entry_t        found_next;
    logic          in_accept;
    logic          finish_go;
    logic          rd_en;
    entry_t        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          upd_en;
    logic [AW-1:0] upd_addr;
    entry_t        upd_data;

    scan_status_t  scan_st;
    logic [AW-1:0] match_idx;
    entry_t        match_entry;
    logic [AW-1:0] free_idx;
    logic [AW-1:0] best_idx;
    entry_t        best_entry;

    assign s_ready   = (state_reg == S_IDLE);
    assign in_accept = s_valid && s_ready;
    assign finish_go = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);
    assign rd_en     = (state_reg == S_SCAN) && !issue_done_reg;

    tlq_slot_mem #(.DEPTH(CAPACITY)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    tlq_scan #(.DEPTH(CAPACITY)) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_accept),
        .rd_vld      (data_vld_reg),
        .rd_idx      (data_idx_reg),
        .rd_entry    (rd_data),
        .key_id      (id_reg),
        .status      (scan_st),
        .match_idx   (match_idx),
        .match_entry (match_entry),
        .free_idx    (free_idx),
        .best_idx    (best_idx),
        .best_entry  (best_entry)
    );

    always_comb begin
        status_next         = ST_OK;
        found_next          = '0;
        upd_en              = 1'b0;
        upd_addr            = match_idx;
        upd_data            = match_entry;
        held_count_next     = held_count_reg;
        insert_counter_next = insert_counter_reg;
        unique case (action_reg)
            ACT_REGISTER: begin
                if (scan_st.hit) begin
                    status_next = ST_DUP;
                end else if (hour_reg > MAX_HOUR || minute_reg > MAX_MINUTE) begin
                    status_next = ST_BAD;
                end else if (!scan_st.free_hit) begin
                    status_next = ST_FULL;
                end else begin
                    upd_en              = 1'b1;
                    upd_addr            = free_idx;
                    upd_data            = '{valid: 1'b1, id: id_reg, hour: hour_reg,
                                            minute: minute_reg, level: LOW_LEVEL,
                                            order: insert_counter_reg};
                    insert_counter_next = insert_counter_reg + 32'd1;
                    held_count_next     = held_count_reg + HW'(1);
                end
            end
            ACT_SET_PRIO: begin
                if (!scan_st.hit) begin
                    status_next = ST_NOTFOUND;
                end else if (level_reg == NO_LEVEL) begin
                    status_next = ST_BAD;
                end else begin
                    upd_en              = 1'b1;
                    upd_data.level      = level_reg;
                    upd_data.order      = insert_counter_reg;
                    insert_counter_next = insert_counter_reg + 32'd1;
                end
            end
            ACT_SERVE: begin
                if (!scan_st.best_hit) begin
                    status_next = ST_EMPTY;
                end else begin
                    found_next     = best_entry;
                    upd_en         = 1'b1;
                    upd_addr       = best_idx;
                    upd_data       = best_entry;
                    upd_data.valid = 1'b0;
                    if (held_count_reg != '0) begin
                        held_count_next = held_count_reg - HW'(1);
                    end
                end
            end
            ACT_LOOKUP: begin
                if (!scan_st.hit) begin
                    status_next = ST_NOTFOUND;
                end else begin
                    found_next = match_entry;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb begin
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = addr_reg;
            wr_data = '0;
        end else begin
            wr_en   = finish_go && upd_en;
            wr_addr = upd_addr;
            wr_data = upd_data;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (addr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (data_vld_reg && data_idx_reg == LAST_IDX) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (finish_go) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_CLEAR;
            addr_reg           <= '0;
            issue_done_reg     <= 1'b0;
            data_vld_reg       <= 1'b0;
            held_count_reg     <= '0;
            insert_counter_reg <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg    <= state_next;
            data_vld_reg <= rd_en;
            if (state_reg == S_CLEAR) begin
                addr_reg <= (addr_reg == LAST_IDX) ? '0 : addr_reg + AW'(1);
            end else if (in_accept) begin
                addr_reg       <= '0;
                issue_done_reg <= 1'b0;
            end else if (rd_en) begin
                if (addr_reg == LAST_IDX) begin
                    issue_done_reg <= 1'b1;
                end else begin
                    addr_reg <= addr_reg + AW'(1);
                end
            end
            if (finish_go) begin
                held_count_reg     <= held_count_next;
                insert_counter_reg <= insert_counter_next;
                m_valid_reg        <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_idx_reg <= addr_reg;
        if (in_accept) begin
            action_reg <= s_action;
            id_reg     <= s_ticket_id;
            hour_reg   <= s_arrival_hour;
            minute_reg <= s_arrival_minute;
            level_reg  <= s_new_level;
        end
        if (finish_go) begin
            status_reg       <= status_next;
            found_id_reg     <= found_next.id;
            found_hour_reg   <= found_next.hour;
            found_minute_reg <= found_next.minute;
            found_level_reg  <= found_next.level;
            pending_reg      <= 7'(held_count_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_found_id      = found_id_reg;
    assign m_found_hour    = found_hour_reg;
    assign m_found_minute  = found_minute_reg;
    assign m_found_level   = found_level_reg;
    assign m_pending_count = pending_reg;

endmodule
